// File: hw/rtl/ssnf_pkg.sv
// ----------------------------------------------------------------------------
// ssnf_pkg
// Shared types, constants and the segment lookup for the number formatter.
// ----------------------------------------------------------------------------
package ssnf_pkg;

  // Digit group limit and counter width (counter must hold the limit itself)
  localparam int unsigned MaxDigits = 16;
  localparam int unsigned PosW      = 5;
  localparam int unsigned CfgW      = 5;

  localparam logic [PosW-1:0] MaxDigitsV   = PosW'(MaxDigits);
  localparam logic [CfgW-1:0] NumDigitsRst = CfgW'(4);

  localparam logic [7:0] CharDot = 8'h2E;

  typedef enum logic {
    StIdle,
    StFill
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic take_in;    // accept the input word this cycle
    logic fill_step;  // load one blank fill result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;    // output register free at this edge
    logic fill_needed;  // current input word leaves positions to blank
    logic fill_last;    // current fill position is the last one
  } dp_status_t;

  // bit0 = segment A ... bit6 = segment G; unknown codes are blank
  function automatic logic [6:0] seg_lookup(input logic [7:0] code);
    logic [6:0] seg;
    seg = 7'h00;
    case (code)
      8'h20: seg = 7'h00;  // space
      8'h2D: seg = 7'h40;  // minus
      8'h30: seg = 7'h3F;
      8'h31: seg = 7'h06;
      8'h32: seg = 7'h5B;
      8'h33: seg = 7'h4F;
      8'h34: seg = 7'h66;
      8'h35: seg = 7'h6D;
      8'h36: seg = 7'h7D;
      8'h37: seg = 7'h07;
      8'h38: seg = 7'h7F;
      8'h39: seg = 7'h6F;
      8'h41: seg = 7'h77;  // A
      8'h42: seg = 7'h7F;
      8'h43: seg = 7'h39;
      8'h44: seg = 7'h3F;
      8'h45: seg = 7'h79;
      8'h46: seg = 7'h71;
      8'h47: seg = 7'h3D;
      8'h48: seg = 7'h76;
      8'h49: seg = 7'h06;
      8'h4A: seg = 7'h1E;
      8'h4B: seg = 7'h70;
      8'h4C: seg = 7'h38;
      8'h4D: seg = 7'h2B;
      8'h4E: seg = 7'h37;
      8'h4F: seg = 7'h3F;
      8'h50: seg = 7'h73;
      8'h51: seg = 7'h6B;
      8'h52: seg = 7'h31;
      8'h53: seg = 7'h6D;
      8'h54: seg = 7'h31;
      8'h55: seg = 7'h3E;
      8'h56: seg = 7'h3E;
      8'h57: seg = 7'h6A;
      8'h58: seg = 7'h76;
      8'h59: seg = 7'h66;
      8'h5A: seg = 7'h5B;  // Z
      8'h61: seg = 7'h5F;  // a
      8'h62: seg = 7'h7C;
      8'h63: seg = 7'h58;
      8'h64: seg = 7'h5E;
      8'h65: seg = 7'h73;
      8'h66: seg = 7'h71;
      8'h67: seg = 7'h6F;
      8'h68: seg = 7'h74;
      8'h69: seg = 7'h04;
      8'h6A: seg = 7'h0C;
      8'h6B: seg = 7'h75;
      8'h6C: seg = 7'h30;
      8'h6D: seg = 7'h55;
      8'h6E: seg = 7'h54;
      8'h6F: seg = 7'h5C;
      8'h70: seg = 7'h73;
      8'h71: seg = 7'h67;
      8'h72: seg = 7'h50;
      8'h73: seg = 7'h50;
      8'h74: seg = 7'h78;
      8'h75: seg = 7'h1C;
      8'h76: seg = 7'h50;
      8'h77: seg = 7'h50;
      8'h78: seg = 7'h50;
      8'h79: seg = 7'h50;
      8'h7A: seg = 7'h50;  // z
      8'hF1: seg = 7'h55;
      8'hF6: seg = 7'h5D;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// File: hw/rtl/seven_segment_number_formatter_top.sv
// ----------------------------------------------------------------------------
// seven_segment_number_formatter_top
// Turns a number string, rightmost character first, into seven-segment words.
// ----------------------------------------------------------------------------
// Usage:
//   - Input channel (in_valid_i / in_stall_o): one character word per
//     transfer. has_char_i = 0 or end_of_string_i = 1 closes the string.
//   - Output channel (out_valid_o / out_stall_i): one word per digit
//     written; last_result_o marks the final word caused by an input word.
//   - Config channel (cfg_valid_i / cfg_ready_o): digit count, always ready.
//     Write only while the block is idle. Values above 16 act as 16.
// Timing:
//   - A character result is registered and shows in the cycle after accept.
//   - A character word is taken every cycle while the output drains.
//   - A string end blanks the remaining positions at one word per cycle
//     while the output drains, run by the fill state of the controller;
//     input is stalled meanwhile.
// Stall: a stalled output word holds; the input stalls while the output
//   register is full and stalled, so nothing is lost.
// Reset: position counter and pending point clear, digit count is 4,
//   output register empty.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ssnf_pkg::CfgW-1:0] cfg_num_digits_i,
  // character input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      has_char_i,
  input  logic [7:0]                char_code_i,
  input  logic                      end_of_string_i,
  // digit output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [3:0]                digit_position_o,
  output logic [6:0]                segments_o,
  output logic                      decimal_point_o,
  output logic                      last_result_o
);
  import ssnf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register write is never back-pressured
  assign cfg_ready_o = 1'b1;

  ssnf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssnf_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i && cfg_ready_o),
    .cfg_num_digits_i (cfg_num_digits_i),
    .has_char_i       (has_char_i),
    .char_code_i      (char_code_i),
    .end_of_string_i  (end_of_string_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digit_position_o (digit_position_o),
    .segments_o       (segments_o),
    .decimal_point_o  (decimal_point_o),
    .last_result_o    (last_result_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

  // No input word is taken while the fill sequence runs
  a_no_accept_in_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fill_step |-> !(in_valid_i && !in_stall_o))
    else $error("input accepted during fill");

  // A load only happens into a free output register
  a_load_into_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take_in || cmd.fill_step) |-> status.slot_free)
    else $error("output register overwritten");

  // Once a non-final word drains, the next word of the same input follows
  a_burst_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_result_o) |=> out_valid_o)
    else $error("gap inside a result burst");

  // Fill words are always blank with the point off
  a_fill_blank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fill_step |=> (segments_o == 7'h00) && !decimal_point_o)
    else $error("fill word not blank");

endmodule

// File: hw/rtl/ssnf_ctrl.sv
// ----------------------------------------------------------------------------
// ssnf_ctrl
// Sequencer: takes input words, then steps the blank fill of a string end.
// ----------------------------------------------------------------------------
module ssnf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ssnf_pkg::dp_status_t  status_i,
  output ssnf_pkg::ctrl_cmd_t   cmd_o
);
  import ssnf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_stall_o      = 1'b1;
    cmd_o.take_in   = 1'b0;
    cmd_o.fill_step = 1'b0;
    case (state_q)
      StIdle: begin
        in_stall_o    = !status_i.slot_free;
        cmd_o.take_in = in_valid_i && status_i.slot_free;
        if (cmd_o.take_in && status_i.fill_needed) begin
          state_d = StFill;
        end
      end
      StFill: begin
        cmd_o.fill_step = status_i.slot_free;
        if (status_i.slot_free && status_i.fill_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// File: hw/rtl/ssnf_datapath.sv
// ----------------------------------------------------------------------------
// ssnf_datapath
// Position counter, pending point, digit count and the output register.
// ----------------------------------------------------------------------------
module ssnf_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [ssnf_pkg::CfgW-1:0] cfg_num_digits_i,
  input  logic                      has_char_i,
  input  logic [7:0]                char_code_i,
  input  logic                      end_of_string_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [3:0]                digit_position_o,
  output logic [6:0]                segments_o,
  output logic                      decimal_point_o,
  output logic                      last_result_o,
  input  ssnf_pkg::ctrl_cmd_t       cmd_i,
  output ssnf_pkg::dp_status_t      status_o
);
  import ssnf_pkg::*;

  logic [CfgW-1:0] num_digits_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic            dot_q, dot_d;
  logic            out_valid_q, out_valid_d;
  logic [3:0]      pos_out_q, pos_out_d;
  logic [6:0]      seg_q, seg_d;
  logic            dp_q, dp_d;
  logic            last_q, last_d;

  logic [PosW-1:0] n_digits;
  logic [PosW-1:0] pos_inc;
  logic [PosW-1:0] pos_after;
  logic            room;
  logic            is_end;
  logic            emit_char;
  logic            fill_needed;
  logic            fill_last;

  assign n_digits    = (PosW'(num_digits_q) > MaxDigitsV) ? MaxDigitsV : PosW'(num_digits_q);
  assign pos_inc     = pos_q + PosW'(1);
  assign room        = pos_q < n_digits;
  assign is_end      = !has_char_i || end_of_string_i;
  assign emit_char   = has_char_i && room && (char_code_i != CharDot);
  assign pos_after   = emit_char ? pos_inc : pos_q;
  assign fill_needed = is_end && (pos_after < n_digits);
  assign fill_last   = pos_inc >= n_digits;

  assign status_o.slot_free   = !out_valid_q || !out_stall_i;
  assign status_o.fill_needed = fill_needed;
  assign status_o.fill_last   = fill_last;

  always_comb begin
    pos_d       = pos_q;
    dot_d       = dot_q;
    out_valid_d = out_valid_q && out_stall_i;
    pos_out_d   = pos_out_q;
    seg_d       = seg_q;
    dp_d        = dp_q;
    last_d      = last_q;
    if (cmd_i.take_in) begin
      if (has_char_i && room && (char_code_i == CharDot)) begin
        dot_d = 1'b1;
      end
      if (emit_char) begin
        out_valid_d = 1'b1;
        pos_out_d   = pos_q[3:0];
        seg_d       = seg_lookup(char_code_i);
        dp_d        = dot_q;
        last_d      = !fill_needed;
        pos_d       = pos_inc;
        dot_d       = 1'b0;
      end
      if (is_end) begin
        dot_d = 1'b0;
        pos_d = fill_needed ? pos_after : '0;
      end
    end else if (cmd_i.fill_step) begin
      out_valid_d = 1'b1;
      pos_out_d   = pos_q[3:0];
      seg_d       = 7'h00;
      dp_d        = 1'b0;
      last_d      = fill_last;
      pos_d       = fill_last ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_digits_q <= NumDigitsRst;
      pos_q        <= '0;
      dot_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        num_digits_q <= cfg_num_digits_i;
      end
      pos_q       <= pos_d;
      dot_q       <= dot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_out_q <= pos_out_d;
    seg_q     <= seg_d;
    dp_q      <= dp_d;
    last_q    <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign digit_position_o = pos_out_q;
  assign segments_o       = seg_q;
  assign decimal_point_o  = dp_q;
  assign last_result_o    = last_q;

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seven-segment number formatter: drives number
// strings rightmost character first, predicts every digit word in a
// scoreboard and compares each word the block hands out, under random idling
// on both channels and across several digit counts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssnf_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned QuietWait  = 4;   // covers a word that writes nothing
  localparam int unsigned PhaseQuota = 14;  // used words per random phase

  // One expected digit word
  typedef struct packed {
    logic [3:0] pos;
    logic [6:0] seg;
    logic       dp;
    logic       last;
  } digit_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: digit-count register, write pointer and armed point, plus the
  // queue of digit words still owed by the block.
  // --------------------------------------------------------------------------
  class digit_scoreboard;
    logic [6:0]  glyph [256];
    logic [4:0]  digit_limit;
    logic [4:0]  write_pos;
    bit          point_armed;
    digit_word_t owed_words [$];
    int unsigned errors;

    function new();
      logic [6:0] digit_pat [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                     7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
      logic [6:0] upper_pat [26] = '{7'h77, 7'h7F, 7'h39, 7'h3F, 7'h79, 7'h71,
                                     7'h3D, 7'h76, 7'h06, 7'h1E, 7'h70, 7'h38,
                                     7'h2B, 7'h37, 7'h3F, 7'h73, 7'h6B, 7'h31,
                                     7'h6D, 7'h31, 7'h3E, 7'h3E, 7'h6A, 7'h76,
                                     7'h66, 7'h5B};
      logic [6:0] lower_pat [26] = '{7'h5F, 7'h7C, 7'h58, 7'h5E, 7'h73, 7'h71,
                                     7'h6F, 7'h74, 7'h04, 7'h0C, 7'h75, 7'h30,
                                     7'h55, 7'h54, 7'h5C, 7'h73, 7'h67, 7'h50,
                                     7'h50, 7'h78, 7'h1C, 7'h50, 7'h50, 7'h50,
                                     7'h50, 7'h50};
      for (int c = 0; c < 256; c++) glyph[c] = 7'h00;
      for (int c = 0; c < 10; c++) glyph[8'h30 + c] = digit_pat[c];
      for (int c = 0; c < 26; c++) begin
        glyph[8'h41 + c] = upper_pat[c];
        glyph[8'h61 + c] = lower_pat[c];
      end
      glyph["-"]   = 7'h40;
      glyph[8'hF1] = 7'h55;
      glyph[8'hF6] = 7'h5D;
      digit_limit  = NumDigitsRst;
      write_pos    = '0;
      point_armed  = 1'b0;
      errors       = 0;
    endfunction

    function void set_count(logic [CfgW-1:0] value);
      digit_limit = value;
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction

    // Notes one accepted input word; returns 1 unless the word was ignored.
    function bit note_char(logic has_char, logic [7:0] code, logic eos);
      int unsigned n;
      int unsigned made;
      bit          used;
      bit          closes;
      digit_word_t w;
      n      = (digit_limit > MaxDigits) ? MaxDigits : digit_limit;
      made   = 0;
      used   = 1'b0;
      closes = !has_char || eos;
      if (has_char && write_pos < n) begin
        used = 1'b1;
        if (code == CharDot) begin
          point_armed = 1'b1;
        end else begin
          w = '{pos: write_pos[3:0], seg: glyph[code], dp: point_armed, last: 1'b0};
          owed_words.push_back(w);
          made++;
          write_pos   = write_pos + 5'd1;
          point_armed = 1'b0;
        end
      end
      if (closes) begin
        used = 1'b1;
        for (int p = write_pos; p < n && made < MaxDigits; p++) begin
          w = '{pos: 4'(p), seg: 7'h00, dp: 1'b0, last: 1'b0};
          owed_words.push_back(w);
          made++;
        end
        write_pos   = '0;
        point_armed = 1'b0;
      end
      // final word of this step carries the marker
      if (made > 0) begin
        w      = owed_words.pop_back();
        w.last = 1'b1;
        owed_words.push_back(w);
      end
      return used;
    endfunction

    task report(string msg);
      if (errors < 40) $display("tb_top: mismatch: %s", msg);
      errors++;
    endtask

    task check_word(logic [3:0] pos, logic [6:0] seg, logic dp, logic last);
      digit_word_t w;
      if (owed_words.size() == 0) begin
        report($sformatf("unexpected word pos=%0d seg=%02h dp=%0b last=%0b",
                         pos, seg, dp, last));
        return;
      end
      w = owed_words.pop_front();
      if (pos !== w.pos)
        report($sformatf("digit_position %0d, want %0d", pos, w.pos));
      if (seg !== w.seg)
        report($sformatf("segments %02h, want %02h at pos %0d", seg, w.seg, w.pos));
      if (dp !== w.dp)
        report($sformatf("decimal_point %0b, want %0b at pos %0d", dp, w.dp, w.pos));
      if (last !== w.last)
        report($sformatf("last_result %0b, want %0b at pos %0d", last, w.last, w.pos));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block hookup
  // --------------------------------------------------------------------------
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CfgW-1:0]  cfg_num_digits = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             has_char = 1'b0;
  logic [7:0]       char_code = '0;
  logic             end_of_string = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [3:0]       digit_position;
  logic [6:0]       segments;
  logic             decimal_point;
  logic             last_result;

  int unsigned      tx_idle_pct = 0;   // sender gap chance per cycle
  int unsigned      rx_stall_pct = 0;  // receiver stall chance per cycle
  int unsigned      used_words = 0;    // input words that were not ignored
  int unsigned      cycles = 0;

  digit_scoreboard  sb = new();

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  seven_segment_number_formatter_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_num_digits_i (cfg_num_digits),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .has_char_i       (has_char),
    .char_code_i      (char_code),
    .end_of_string_i  (end_of_string),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .digit_position_o (digit_position),
    .segments_o       (segments),
    .decimal_point_o  (decimal_point),
    .last_result_o    (last_result)
  );

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Output side: check the word taken at this edge, then pick the next stall.
  // Values read here are the ones settled before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      sb.check_word(digit_position, segments, decimal_point, last_result);
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one word and returns once it is taken. Valid stays high after the
  // accept, so a following word goes out back to back.
  task automatic send_word(logic hc, logic [7:0] code, logic eos);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid      <= 1'b0;
      has_char      <= 1'($urandom_range(1));   // junk while idle
      char_code     <= 8'($urandom_range(255));
      end_of_string <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    has_char      <= hc;
    char_code     <= code;
    end_of_string <= eos;
    do @(posedge clk_i); while (in_stall);
    if (sb.note_char(hc, code, eos)) used_words++;
  endtask

  // Sends a string as written, so the rightmost character goes first
  task automatic send_number(string s, bit close);
    for (int i = s.len() - 1; i >= 0; i--)
      send_word(1'b1, s[i], close && (i == 0));
  endtask

  // Drops valid and waits until every owed word has come out
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (QuietWait) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CfgW-1:0] value);
    wait_quiet();
    cfg_num_digits <= value;
    cfg_valid      <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_count(value);
    cfg_valid <= 1'b0;
  endtask

  // Mostly digits and points, the rest from the table and anywhere in 0..255
  function automatic logic [7:0] rand_char();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return 8'h30 + 8'($urandom_range(9));
    if (pick < 57) return CharDot;
    if (pick < 62) return "-";
    if (pick < 65) return " ";
    if (pick < 73) return 8'h41 + 8'($urandom_range(25));
    if (pick < 81) return 8'h61 + 8'($urandom_range(25));
    if (pick < 85) return $urandom_range(1) ? 8'hF1 : 8'hF6;
    return 8'($urandom_range(255));
  endfunction

  // One random string. Most close properly, on the leftmost character or by
  // an empty word; some run on into the next string, some are pure noise.
  task automatic send_random_string(int unsigned n_eff);
    int unsigned len;
    int unsigned style;
    len   = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(n_eff + 1);
    style = $urandom_range(9);
    if (style == 9) begin
      send_word(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (len == 0) begin
      send_word(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      for (int i = 0; i < len; i++)
        send_word(1'b1, rand_char(), (style <= 5) && (i == len - 1));
      if (style == 6 || style == 7)
        send_word(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CfgW-1:0] phase_count [9];
    int unsigned     n_eff;

    phase_count = '{5'd16, 5'd0, 5'd31, 5'd1, 5'($urandom_range(2, 15)), 5'd7,
                    5'd2, 5'd16, 5'($urandom_range(1, 31))};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, at the reset count of four digits
    tx_idle_pct  = 18;
    rx_stall_pct = 73;
    send_number("1.5", 1'b1);               // point lands on the digit left of it
    send_word(1'b0, 8'hFF, 1'b0);           // empty string: four blank words
    send_word(1'b0, 8'h00, 1'b1);           // empty word with the end flag set
    send_word(1'b1, 8'hF1, 1'b0);
    send_word(1'b1, 8'hF6, 1'b0);
    send_word(1'b1, "-", 1'b0);
    send_word(1'b1, " ", 1'b0);             // group now full
    send_word(1'b1, CharDot, 1'b0);         // ignored, point included
    send_word(1'b1, 8'hFF, 1'b0);           // ignored
    send_word(1'b1, 8'h00, 1'b1);           // end when full: no words at all
    send_number(".123", 1'b1);              // leftmost point is dropped
    send_word(1'b1, 8'h00, 1'b0);           // unknown codes still take a slot
    send_word(1'b1, 8'hFF, 1'b0);
    send_word(1'b1, "Z", 1'b0);
    send_word(1'b0, 8'h55, 1'b1);
    // count lowered to the write pointer while a point is armed
    send_word(1'b1, "7", 1'b0);
    send_word(1'b1, CharDot, 1'b0);
    write_count(5'd1);
    send_word(1'b1, "9", 1'b0);             // pointer at count: ignored
    send_word(1'b1, "x", 1'b1);             // end with nothing left to blank

    // Random phases; idling pattern changes every third phase
    for (int ph = 0; ph < 9; ph++) begin
      write_count(phase_count[ph]);
      if (ph < 3) begin
        tx_idle_pct  = 18;
        rx_stall_pct = 73;
      end else if (ph < 6) begin
        tx_idle_pct  = 73;
        rx_stall_pct = 18;
      end else begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      n_eff      = (phase_count[ph] > MaxDigits) ? MaxDigits : phase_count[ph];
      used_words = 0;
      while (used_words < PhaseQuota) send_random_string(n_eff);
    end

    // Drain and settle, then the verdict
    wait_quiet();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
